### sv/cwmc_pkg.sv
// ----------------------------------------------------------------------------
// cwmc_pkg
// Shared widths and handshake structs for the chroma-weighted mean colour core.
// ----------------------------------------------------------------------------
package cwmc_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned ProdW  = 16;
  localparam int unsigned AccW   = 32;
  localparam int unsigned WaccW  = 24;
  localparam int unsigned NumCh  = 3;
  localparam int unsigned ChSelW = 2;

  typedef struct packed {
    logic             start;
    logic [AccW-1:0]  dividend;
    logic [WaccW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [ChanW-1:0] quotient;
  } div_rsp_t;

endpackage

### sv/cwmc_div.sv
// ----------------------------------------------------------------------------
// cwmc_div
// Restoring divider, one quotient bit per cycle. Keeps the low quotient byte.
// ----------------------------------------------------------------------------
module cwmc_div import cwmc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(AccW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AccW-1:0]  dvd_q, dvd_d;
  logic [WaccW-1:0] dvs_q, dvd_s_d;
  logic [WaccW-1:0] rem_q, rem_d;
  logic [ChanW-1:0] quo_q, quo_d;
  logic [WaccW:0]   trial;
  logic [WaccW:0]   diff;
  logic             ge;

  assign trial = {rem_q, dvd_q[AccW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    dvd_s_d = dvs_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    if (req_i.start && !busy_q) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      dvd_d   = req_i.dividend;
      dvd_s_d = req_i.divisor;
      rem_d   = '0;
      quo_d   = '0;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so it fits back in WaccW bits.
      rem_d = ge ? diff[WaccW-1:0] : trial[WaccW-1:0];
      quo_d = {quo_q[ChanW-2:0], ge};
      dvd_d = {dvd_q[AccW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(AccW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvd_s_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

### sv/chroma_weighted_mean_colour_core.sv
// Non-sampled pixel: taken in the idle state, which then stays ready for the next one.
// Sampled pixel: taken, then the shared 8x8 multiplier updates each channel sum in turn.
// Frame end: three 32-step divisions on one restoring divider before the result is
// registered; the input stays stalled until then, so the next frame waits.
// Reset is asynchronous and clears all sums, the sample phase and the result valid.
// ----------------------------------------------------------------------------
// chroma_weighted_mean_colour_core
// Accumulates chroma-weighted channel sums over every SAMPLE_STRIDE-th pixel of an
// RGB565 frame and emits the weighted mean colour after the last pixel.
// ----------------------------------------------------------------------------
module chroma_weighted_mean_colour_core import cwmc_pkg::*; #(
  parameter int unsigned SAMPLE_STRIDE = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [15:0]      pixel_i,
  input  logic             frame_end_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ChanW-1:0] red_o,
  output logic [ChanW-1:0] green_o,
  output logic [ChanW-1:0] blue_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMac  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  localparam logic [ChSelW-1:0] ChLast = ChSelW'(NumCh - 1);

  logic [1:0]        state_q, state_d;
  logic [1:0]        phase_q, phase_d;
  logic [2:0]        phase_inc;
  logic [ChSelW-1:0] chan_q, chan_d;
  logic              last_q, last_d;
  logic              go_q, go_d;
  logic              out_valid_q, out_valid_d;

  logic [AccW-1:0]   acc_q [NumCh];
  logic [WaccW-1:0]  wacc_q;
  logic [ChanW-1:0]  ch_q  [NumCh];
  logic [ChanW-1:0]  w_q;
  logic [ChanW-1:0]  res_q [NumCh];
  logic [ChanW-1:0]  out_q [NumCh];

  logic [ChanW-1:0]  r_x, g_x, b_x, mx, mn, w_x;
  logic [ProdW-1:0]  prod;
  logic              accept;
  logic              load_out;
  logic              clear_acc;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign r_x = {pixel_i[15:11], 3'b000};
  assign g_x = {pixel_i[10:5], 2'b00};
  assign b_x = {pixel_i[4:0], 3'b000};

  always_comb begin
    mx = (r_x > g_x) ? r_x : g_x;
    mx = (mx > b_x) ? mx : b_x;
    mn = (r_x < g_x) ? r_x : g_x;
    mn = (mn < b_x) ? mn : b_x;
  end

  // The spread is at most 252, so the weight fits in a byte.
  assign w_x       = mx - mn + 8'd1;
  assign prod      = ch_q[chan_q] * w_q;
  assign accept    = in_valid_i && (state_q == StIdle);
  assign phase_inc = {1'b0, phase_q} + 3'd1;
  assign load_out  = (state_q == StOut) && (!out_valid_q || !out_stall_i);
  assign clear_acc = load_out;

  assign div_req.start    = go_q;
  assign div_req.dividend = acc_q[chan_q];
  assign div_req.divisor  = wacc_q;

  cwmc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    chan_d      = chan_q;
    last_d      = last_q;
    go_d        = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (accept) begin
          last_d  = frame_end_i;
          chan_d  = '0;
          phase_d = (phase_inc >= 3'(SAMPLE_STRIDE)) ? 2'd0 : phase_inc[1:0];
          if (frame_end_i) begin
            phase_d = 2'd0;
          end
          if (phase_q == 2'd0) begin
            state_d = StMac;
          end else if (frame_end_i) begin
            state_d = StDiv;
            go_d    = 1'b1;
          end
        end
      end
      StMac: begin
        if (chan_q == ChLast) begin
          chan_d = '0;
          if (last_q) begin
            state_d = StDiv;
            go_d    = 1'b1;
          end else begin
            state_d = StIdle;
          end
        end else begin
          chan_d = chan_q + 1'b1;
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          if (chan_q == ChLast) begin
            state_d = StOut;
          end else begin
            chan_d = chan_q + 1'b1;
            go_d   = 1'b1;
          end
        end
      end
      StOut: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= 2'd0;
      chan_q      <= '0;
      last_q      <= 1'b0;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
      wacc_q      <= '0;
      for (int i = 0; i < NumCh; i++) begin
        acc_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      chan_q      <= chan_d;
      last_q      <= last_d;
      go_q        <= go_d;
      out_valid_q <= out_valid_d;
      if (clear_acc) begin
        wacc_q <= '0;
        for (int i = 0; i < NumCh; i++) begin
          acc_q[i] <= '0;
        end
      end else if (state_q == StMac) begin
        acc_q[chan_q] <= acc_q[chan_q] + AccW'(prod);
        if (chan_q == '0) begin
          wacc_q <= wacc_q + WaccW'(w_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q[0] <= r_x;
      ch_q[1] <= g_x;
      ch_q[2] <= b_x;
      w_q     <= w_x;
    end
    if (state_q == StDiv && div_rsp.done) begin
      res_q[chan_q] <= div_rsp.quotient;
    end
    if (load_out) begin
      // A zero weight sum can only come from wrap-around; the mean is then zero.
      for (int i = 0; i < NumCh; i++) begin
        out_q[i] <= (wacc_q == '0) ? '0 : res_q[i];
      end
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign red_o       = out_q[0];
  assign green_o     = out_q[1];
  assign blue_o      = out_q[2];

endmodule

### sv/cwmc_checker.sv
// ----------------------------------------------------------------------------
// cwmc_checker
// Port-level checks for the chroma-weighted mean colour core.
// ----------------------------------------------------------------------------
module cwmc_checker import cwmc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [15:0]      pixel_i,
  input logic             frame_end_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [ChanW-1:0] red_o,
  input logic [ChanW-1:0] green_o,
  input logic [ChanW-1:0] blue_o
);

  // The last pixel of a frame always starts the division sequence.
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && frame_end_i |=> in_stall_o)
    else $error("core took a transaction right after the frame end");

  // A result only appears at the end of a busy period.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a division sequence");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result was dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(red_o) && $stable(green_o) && $stable(blue_o))
    else $error("stalled result changed");

endmodule

bind chroma_weighted_mean_colour_core cwmc_checker u_cwmc_checker (.*);

### tb/chroma_mean_checker.sv
// ----------------------------------------------------------------------------
// chroma_mean_checker
// Watches the pixel input and the result output of the weighted mean colour core. It keeps its own
// copy of the frame sums and checks each result against the oldest prediction.
// ----------------------------------------------------------------------------
module chroma_mean_checker import cwmc_pkg::*; #(
  parameter int unsigned SAMPLE_STRIDE = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [15:0]      pixel_i,
  input  logic             frame_end_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } colour_t;

  colour_t          mean_q[$];
  colour_t          want;
  logic [1:0]       stride_pos;
  logic [AccW-1:0]  red_sum;
  logic [AccW-1:0]  green_sum;
  logic [AccW-1:0]  blue_sum;
  logic [WaccW-1:0] weight_sum;
  int unsigned      fails;

  function automatic logic [ChanW-1:0] mean_of(input logic [AccW-1:0]  sum,
                                               input logic [WaccW-1:0] wsum);
    logic [AccW-1:0] quot;
    quot = sum / AccW'(wsum);
    return quot[ChanW-1:0];
  endfunction

  task automatic clear_frame();
    stride_pos = '0;
    red_sum    = '0;
    green_sum  = '0;
    blue_sum   = '0;
    weight_sum = '0;
  endtask

  task automatic take_pixel(input logic [15:0] px, input logic last);
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
    logic [ChanW-1:0] hi;
    logic [ChanW-1:0] lo;
    logic [ChanW:0]   w;
    colour_t          m;
    if (stride_pos == 2'd0) begin
      r  = {px[15:11], 3'b000};
      g  = {px[10:5], 2'b00};
      b  = {px[4:0], 3'b000};
      hi = (r > g) ? r : g;
      if (b > hi) hi = b;
      lo = (r < g) ? r : g;
      if (b < lo) lo = b;
      w = 9'd1 + hi - lo;
      red_sum    = red_sum + r * w;
      green_sum  = green_sum + g * w;
      blue_sum   = blue_sum + b * w;
      weight_sum = weight_sum + w;
    end
    stride_pos = (int'(stride_pos) + 1 >= SAMPLE_STRIDE) ? 2'd0 : stride_pos + 2'd1;
    if (last) begin
      // The weight sum can only reach zero after it has wrapped.
      if (weight_sum == '0) begin
        m = '0;
      end else begin
        m.red   = mean_of(red_sum, weight_sum);
        m.green = mean_of(green_sum, weight_sum);
        m.blue  = mean_of(blue_sum, weight_sum);
      end
      mean_q.push_back(m);
      clear_frame();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q.delete();
      clear_frame();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) take_pixel(pixel_i, frame_end_i);
      if (out_valid_i && !out_stall_i) begin
        if (mean_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0d %0d %0d",
                   $time, red_i, green_i, blue_i);
          fails++;
        end else begin
          want = mean_q.pop_front();
          if (red_i !== want.red) begin
            $display("%0t: red mismatch, expected %0d, got %0d", $time, want.red, red_i);
            fails++;
          end
          if (green_i !== want.green) begin
            $display("%0t: green mismatch, expected %0d, got %0d",
                     $time, want.green, green_i);
            fails++;
          end
          if (blue_i !== want.blue) begin
            $display("%0t: blue mismatch, expected %0d, got %0d", $time, want.blue, blue_i);
            fails++;
          end
        end
      end
      fail_count_o <= fails;
      pending_o    <= mean_q.size();
    end
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams frames of RGB565 pixels into the weighted mean colour core with
// random gaps and output stalls, including one long output hold-off.
// The checker judges every result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cwmc_pkg::*;

  localparam int unsigned SampleStride = 4;
  localparam int unsigned RandomPixels = 1150;
  localparam int unsigned HoldCycles   = 1500;
  localparam int unsigned SettleCycles = 300;
  localparam int unsigned CycleLimit   = 3_000_000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [15:0]      pixel;
  logic             frame_end;
  logic             out_valid;
  logic             out_stall;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;
  logic             hold_req;
  int unsigned      fail_count;
  int unsigned      pending_count;
  int unsigned      pixels_sent = 0;
  int unsigned      cycle_count = 0;
  bit               tx_gaps;

  chroma_weighted_mean_colour_core #(
    .SAMPLE_STRIDE(SampleStride)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .pixel_i    (pixel),
    .frame_end_i(frame_end),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .red_o      (red),
    .green_o    (green),
    .blue_o     (blue)
  );

  chroma_mean_checker #(
    .SAMPLE_STRIDE(SampleStride)
  ) mean_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .pixel_i     (pixel),
    .frame_end_i (frame_end),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .red_i       (red),
    .green_i     (green),
    .blue_i      (blue),
    .fail_count_o(fail_count),
    .pending_o   (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic logic [15:0] random_pixel();
    logic [2:0] pick;
    logic [4:0] level;
    pick  = 3'($urandom);
    level = 5'($urandom);
    case ($urandom_range(0, 3))
      // Near gray: small spread, so weights stay low.
      0: random_pixel = {level, level, pick[0], level};
      1: random_pixel = {{5{pick[0]}}, {6{pick[1]}}, {5{pick[2]}}};
      default: random_pixel = 16'($urandom);
    endcase
  endfunction

  // One pixel transaction; valid stays high into the next one unless a gap is drawn.
  task automatic send_pixel(input logic [15:0] px, input logic last);
    int unsigned gap;
    gap = 0;
    if (tx_gaps) begin
      case ($urandom_range(0, 19))
        0: gap = $urandom_range(10, 40);
        1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
        default: gap = 0;
      endcase
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    pixel     <= px;
    frame_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic send_frame(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_pixel(random_pixel(), i == len - 1);
  endtask

  initial begin : receiver
    int unsigned stall_left;
    int unsigned calm_left;
    bit          hold_taken;
    out_stall  = 1'b0;
    stall_left = 0;
    calm_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (calm_left != 0) calm_left--;
      else if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(100, 600);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = HoldCycles;
      end else if (stall_left == 0 && calm_left == 0 && $urandom_range(0, 5) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                 : $urandom_range(1, 4);
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin : stimulus
    int unsigned rand_start;
    int unsigned len;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    pixel     = '0;
    frame_end = 1'b0;
    hold_req  = 1'b0;
    tx_gaps   = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Single-pixel frames at the channel extremes.
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'hF800, 1'b1);
    send_pixel(16'h07E0, 1'b1);
    send_pixel(16'h001F, 1'b1);
    // Only the first pixel of this frame is sampled.
    send_pixel(16'h1234, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hABCD, 1'b1);
    // The last pixel falls on a sampling slot and counts.
    send_pixel(16'hF81F, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h07FF, 1'b1);
    send_pixel(16'h5555, 1'b0);
    send_pixel(16'hAAAA, 1'b0);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'h8000, 1'b0);
    send_pixel(16'hAAAA, 1'b0);
    send_pixel(16'h0821, 1'b1);

    // Short frames while the receiver holds off, so results back up.
    tx_gaps = 1'b1;
    hold_req <= 1'b1;
    repeat (40) send_frame($urandom_range(1, 3));

    rand_start = pixels_sent;
    while (pixels_sent - rand_start < RandomPixels) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: len = $urandom_range(1, 8);
        6, 7, 8: len = $urandom_range(9, 40);
        default: len = $urandom_range(41, 200);
      endcase
      send_frame(len);
    end

    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### chroma_weighted_mean_colour_core.f
sv/cwmc_pkg.sv
sv/cwmc_div.sv
sv/chroma_weighted_mean_colour_core.sv
sv/cwmc_checker.sv
tb/chroma_mean_checker.sv
tb/testbench.sv
